// ===== rtl/core/pstt_pkg.sv =====
// types, command and status codes shared by the sorted task table modules
package pstt_pkg;

   localparam logic [2:0] CMD_INSERT   = 3'd0;
   localparam logic [2:0] CMD_COMPLETE = 3'd1;
   localparam logic [2:0] CMD_LIST_DN  = 3'd2;
   localparam logic [2:0] CMD_LIST_PND = 3'd3;
   localparam logic [2:0] CMD_CLEAR    = 3'd4;

   localparam logic [2:0] ST_INSERTED  = 3'd0;
   localparam logic [2:0] ST_FULL      = 3'd1;
   localparam logic [2:0] ST_MARKED    = 3'd2;
   localparam logic [2:0] ST_ALR_DONE  = 3'd3;
   localparam logic [2:0] ST_NOT_FOUND = 3'd4;
   localparam logic [2:0] ST_ENTRY     = 3'd5;
   localparam logic [2:0] ST_NONE      = 3'd6;
   localparam logic [2:0] ST_CLEARED   = 3'd7;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [19:0] priority_req;
      logic [15:0] label;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [19:0] out_priority;
      logic [15:0] out_label;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [19:0] prio;
      logic [15:0] label;
      logic        done;
   } entry_type;

   // controller to datapath
   typedef struct packed {
      logic       load;
      logic       rd;
      logic       step;
      logic       wr_shift;
      logic       wr_new;
      logic       wr_mark;
      logic       inc_count;
      logic       clr_count;
      logic       hold;
      logic       emit_code;
      logic [2:0] code;
      logic       emit_held;
      logic       held_last;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic full;
      logic scan_end;
      logic rd_lower;
      logic rd_equal;
      logic rd_done;
      logic have_held;
   } dp_sts_type;

endpackage

// ===== rtl/core/pstt_dp.sv =====
// datapath: entry memory, fill count, scan pointer, held entry and result register
module pstt_dp
   import pstt_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  req_type    req_item,
   input  dp_cmd_type dp_cmd,
   output dp_sts_type dp_sts,
   output logic       rsp_strobe,
   output rsp_type    rsp_item
);

   localparam int AW = $clog2(DEPTH);
   localparam int PW = $clog2(DEPTH + 1);

   entry_type mem [DEPTH];

   req_type        req_ff;
   logic [PW-1:0]  ptr_ff, ptr_in;
   logic [PW-1:0]  count_ff, count_in;
   entry_type      rd_data_ff;
   entry_type      held_ff;
   logic           have_held_ff, have_held_in;
   logic           strobe_ff, strobe_in;
   rsp_type        rsp_ff, rsp_in;

   logic           is_ins;
   logic [PW-1:0]  ptr_dec;
   logic [AW-1:0]  rd_addr;
   logic           wr_en;
   entry_type      wr_data;

   assign is_ins  = (req_ff.cmd == CMD_INSERT);
   assign ptr_dec = ptr_ff - PW'(1);
   // insert walks down from the top, the other scans walk up from entry zero
   assign rd_addr = is_ins ? ptr_dec[AW-1:0] : ptr_ff[AW-1:0];
   assign wr_en   = dp_cmd.wr_shift | dp_cmd.wr_new | dp_cmd.wr_mark;

   always_comb begin
      if (dp_cmd.wr_new) begin
         wr_data = '{prio: req_ff.priority_req, label: req_ff.label, done: 1'b0};
      end else if (dp_cmd.wr_mark) begin
         wr_data = '{prio: rd_data_ff.prio, label: rd_data_ff.label, done: 1'b1};
      end else begin
         wr_data = rd_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[ptr_ff[AW-1:0]] <= wr_data;
      end
      if (dp_cmd.rd) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      ptr_in = ptr_ff;
      if (dp_cmd.load) begin
         ptr_in = (req_item.cmd == CMD_INSERT) ? count_ff : '0;
      end else if (dp_cmd.step) begin
         ptr_in = is_ins ? ptr_dec : ptr_ff + PW'(1);
      end

      count_in = count_ff;
      if (dp_cmd.clr_count) begin
         count_in = '0;
      end else if (dp_cmd.inc_count) begin
         count_in = count_ff + PW'(1);
      end

      have_held_in = have_held_ff;
      if (dp_cmd.load) begin
         have_held_in = 1'b0;
      end else if (dp_cmd.hold) begin
         have_held_in = 1'b1;
      end

      strobe_in = dp_cmd.emit_code | dp_cmd.emit_held;
      if (dp_cmd.emit_held) begin
         rsp_in = '{status: ST_ENTRY, out_priority: held_ff.prio,
                    out_label: held_ff.label, last: dp_cmd.held_last};
      end else begin
         rsp_in = '{status: dp_cmd.code, out_priority: '0, out_label: '0, last: 1'b1};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         have_held_ff <= 1'b0;
         strobe_ff    <= 1'b0;
      end else begin
         count_ff     <= count_in;
         have_held_ff <= have_held_in;
         strobe_ff    <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      rsp_ff <= rsp_in;
      if (dp_cmd.load) begin
         req_ff <= req_item;
      end
      if (dp_cmd.hold) begin
         held_ff <= rd_data_ff;
      end
   end

   assign dp_sts.full      = (count_ff == PW'(DEPTH));
   assign dp_sts.scan_end  = is_ins ? (ptr_ff == '0) : (ptr_ff == count_ff);
   assign dp_sts.rd_lower  = (rd_data_ff.prio < req_ff.priority_req);
   assign dp_sts.rd_equal  = (rd_data_ff.prio == req_ff.priority_req);
   assign dp_sts.rd_done   = rd_data_ff.done;
   assign dp_sts.have_held = have_held_ff;

   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

// ===== rtl/core/pstt_ctrl.sv =====
// controller: sequences insert shifts, complete search and list walks
module pstt_ctrl
   import pstt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic [2:0] req_cmd,
   input  dp_sts_type dp_sts,
   output logic       busy,
   output dp_cmd_type dp_cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_RD   = 2'd1;
   localparam logic [1:0] S_EV   = 2'd2;

   logic [1:0] state_ff, state_in;
   logic [2:0] cmd_ff;
   logic       want_done;

   assign want_done = (cmd_ff == CMD_LIST_DN);

   always_comb begin
      state_in = state_ff;
      dp_cmd   = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               dp_cmd.load = 1'b1;
               unique case (req_cmd) inside
                  CMD_INSERT: begin
                     if (dp_sts.full) begin
                        dp_cmd.emit_code = 1'b1;
                        dp_cmd.code      = ST_FULL;
                     end else begin
                        state_in = S_RD;
                     end
                  end
                  CMD_COMPLETE, CMD_LIST_DN, CMD_LIST_PND: begin
                     state_in = S_RD;
                  end
                  CMD_CLEAR: begin
                     dp_cmd.clr_count = 1'b1;
                     dp_cmd.emit_code = 1'b1;
                     dp_cmd.code      = ST_CLEARED;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_RD: begin
            if (dp_sts.scan_end) begin
               state_in = S_IDLE;
               if (cmd_ff == CMD_INSERT) begin
                  dp_cmd.wr_new    = 1'b1;
                  dp_cmd.inc_count = 1'b1;
                  dp_cmd.emit_code = 1'b1;
                  dp_cmd.code      = ST_INSERTED;
               end else if (cmd_ff == CMD_COMPLETE) begin
                  dp_cmd.emit_code = 1'b1;
                  dp_cmd.code      = ST_NOT_FOUND;
               end else if (dp_sts.have_held) begin
                  dp_cmd.emit_held = 1'b1;
                  dp_cmd.held_last = 1'b1;
               end else begin
                  dp_cmd.emit_code = 1'b1;
                  dp_cmd.code      = ST_NONE;
               end
            end else begin
               dp_cmd.rd = 1'b1;
               state_in  = S_EV;
            end
         end
         S_EV: begin
            state_in = S_RD;
            if (cmd_ff == CMD_INSERT) begin
               if (dp_sts.rd_lower) begin
                  dp_cmd.wr_new    = 1'b1;
                  dp_cmd.inc_count = 1'b1;
                  dp_cmd.emit_code = 1'b1;
                  dp_cmd.code      = ST_INSERTED;
                  state_in         = S_IDLE;
               end else begin
                  dp_cmd.wr_shift = 1'b1;
                  dp_cmd.step     = 1'b1;
               end
            end else if (cmd_ff == CMD_COMPLETE) begin
               if (dp_sts.rd_equal) begin
                  dp_cmd.emit_code = 1'b1;
                  state_in         = S_IDLE;
                  if (dp_sts.rd_done) begin
                     dp_cmd.code = ST_ALR_DONE;
                  end else begin
                     dp_cmd.wr_mark = 1'b1;
                     dp_cmd.code    = ST_MARKED;
                  end
               end else begin
                  dp_cmd.step = 1'b1;
               end
            end else begin
               dp_cmd.step = 1'b1;
               if (dp_sts.rd_done == want_done) begin
                  dp_cmd.hold      = 1'b1;
                  dp_cmd.emit_held = dp_sts.have_held;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start && (state_ff == S_IDLE)) begin
         cmd_ff <= req_cmd;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

// ===== rtl/core/priority_sorted_task_table.sv =====
// top level of the priority-sorted task table
//
//   channel | ports                      | handshake
//   --------+----------------------------+--------------------------------------
//   request | start, busy, req_item      | beat taken when start && !busy
//   result  | rsp_strobe, rsp_item       | one-cycle strobe, receiver never stalls
//
// clear, a full insert and unused codes are handled straight from idle; other
// commands walk the entry memory with a read state and then an evaluate state
// for each entry visited (insert, complete and both lists)
// reset clears the fill count, the held flag and the result strobe; entry memory needs no clearing pass
// results are registered before they leave; busy covers the walk
module priority_sorted_task_table
   import pstt_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_strobe,
   output rsp_type rsp_item
);

   // command and status between the sequencer and the datapath
   dp_cmd_type dp_cmd;
   dp_sts_type dp_sts;

   // sequencer: one state machine for all commands
   pstt_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .req_cmd (req_item.cmd),
      .dp_sts  (dp_sts),
      .busy    (busy),
      .dp_cmd  (dp_cmd)
   );

   // datapath: entry memory kept sorted, with one read port and one write port
   pstt_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_item   (req_item),
      .dp_cmd     (dp_cmd),
      .dp_sts     (dp_sts),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

`ifndef SYNTHESIS
   // a clear beat answers with cleared on the next cycle
   a_clear_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_item.cmd == CMD_CLEAR)) |=>
         (rsp_strobe && (rsp_item.status == ST_CLEARED) && rsp_item.last))
      else $error("clear not answered");

   // only list entries can be followed by more results
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_item.status != ST_ENTRY)) |-> rsp_item.last)
      else $error("non-entry result without last");

   // payload is zero outside list entries
   a_zero_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_item.status != ST_ENTRY)) |->
         ((rsp_item.out_priority == '0) && (rsp_item.out_label == '0)))
      else $error("payload on non-entry result");

   // a non-final entry means the walk is still running
   a_mid_list_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_item.last) |-> busy)
      else $error("list walk ended before last");
`endif

endmodule

// ===== bench/priority_sorted_task_table_tb.sv =====
// self-checking testbench for the priority-sorted task table, with its own table predictor
module priority_sorted_task_table_tb;
   import pstt_pkg::*;

   localparam int TABLE_DEPTH  = 64;
   localparam int HALF_PERIOD  = 6;
   localparam int RANDOM_BEATS = 180;
   localparam int IDLE_PCT     = 36;
   // codes 5 to 7 are spare; the table ignores them
   localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
   localparam logic [2:0] CMD_SPARE_MID   = 3'd6;
   localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;

   // one command waiting in the backlog, with the sender's behavior ahead of it
   typedef struct {
      req_type beat;
      bit      drain;   // hold off until every awaited result has come
      int      gap_pct; // chance of idling on each falling edge before this beat
   } queued_cmd_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_item = '0;
   logic    rsp_strobe;
   rsp_type rsp_item;

   // sender side
   queued_cmd_type cmd_backlog[$];
   logic           beat_taken = 1'b0;

   // predicted table contents and the results still to come
   entry_type   table_entries[TABLE_DEPTH];
   int          table_fill = 0;
   rsp_type     awaited_results[$];

   // stimulus bookkeeping: rough fill and keys inserted since the last clear
   int          gen_fill = 0;
   logic [19:0] gen_keys[$];
   int          cur_gap = IDLE_PCT;
   bit          drain_next = 1'b0;
   int          random_beats = 0;

   int fail_count      = 0;
   int beats_taken     = 0;
   int results_checked = 0;
   int full_rejects    = 0;
   int repeat_marks    = 0;
   int empty_listings  = 0;

   priority_sorted_task_table #(
      .DEPTH(TABLE_DEPTH)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_strobe(rsp_strobe),
      .rsp_item  (rsp_item)
   );

   always #HALF_PERIOD clock = ~clock;

   // ---------------------------------------------------------------------------
   // predictor: applies one accepted beat to the table copy and queues its results
   // ---------------------------------------------------------------------------
   function automatic void predict_results(req_type beat);
      rsp_type   res;
      int        slot;
      int        hit_total;
      int        emitted;
      bit        found;
      logic      want_done;
      begin
         res      = '0;
         res.last = 1'b1;
         case (beat.cmd) inside
            CMD_INSERT: begin
               if (table_fill >= TABLE_DEPTH) begin
                  res.status = ST_FULL;
               end else begin
                  // new entry goes ahead of any entry with an equal key
                  slot = 0;
                  while (slot < table_fill && table_entries[slot].prio < beat.priority_req)
                     slot++;
                  for (int i = table_fill; i > slot; i--)
                     table_entries[i] = table_entries[i - 1];
                  table_entries[slot].prio  = beat.priority_req;
                  table_entries[slot].label = beat.label;
                  table_entries[slot].done  = 1'b0;
                  table_fill++;
                  res.status = ST_INSERTED;
               end
               awaited_results.push_back(res);
            end
            CMD_COMPLETE: begin
               // only the first entry with the key counts, done or not
               found      = 1'b0;
               res.status = ST_NOT_FOUND;
               for (int i = 0; i < table_fill; i++) begin
                  if (!found && table_entries[i].prio == beat.priority_req) begin
                     found = 1'b1;
                     if (table_entries[i].done) begin
                        res.status = ST_ALR_DONE;
                     end else begin
                        table_entries[i].done = 1'b1;
                        res.status = ST_MARKED;
                     end
                  end
               end
               awaited_results.push_back(res);
            end
            CMD_LIST_DN, CMD_LIST_PND: begin
               want_done = (beat.cmd == CMD_LIST_DN);
               hit_total = 0;
               for (int i = 0; i < table_fill; i++)
                  if (table_entries[i].done == want_done) hit_total++;
               if (hit_total == 0) begin
                  res.status = ST_NONE;
                  awaited_results.push_back(res);
               end else begin
                  emitted = 0;
                  for (int i = 0; i < table_fill; i++) begin
                     if (table_entries[i].done == want_done) begin
                        emitted++;
                        res.status       = ST_ENTRY;
                        res.out_priority = table_entries[i].prio;
                        res.out_label    = table_entries[i].label;
                        res.last         = (emitted == hit_total);
                        awaited_results.push_back(res);
                     end
                  end
               end
            end
            CMD_CLEAR: begin
               table_fill = 0;
               res.status = ST_CLEARED;
               awaited_results.push_back(res);
            end
            default: begin
               // spare codes leave the table alone and answer nothing
            end
         endcase
      end
   endfunction

   // compares one result beat with the oldest awaited result
   task automatic check_result(rsp_type got);
      rsp_type want;
      begin
         if (awaited_results.size() == 0) begin
            fail_count++;
            $display("%0t: unexpected result beat: status %0d prio %h label %h last %b",
                     $time, got.status, got.out_priority, got.out_label, got.last);
         end else begin
            want = awaited_results.pop_front();
            results_checked++;
            if (got.status !== want.status || got.out_priority !== want.out_priority ||
                got.out_label !== want.out_label || got.last !== want.last) begin
               fail_count++;
               $display("%0t: mismatch expected status %0d prio %h label %h last %b",
                        $time, want.status, want.out_priority, want.out_label, want.last);
               $display("%0t:          actual   status %0d prio %h label %h last %b",
                        $time, got.status, got.out_priority, got.out_label, got.last);
            end
            case (want.status)
               ST_FULL:     full_rejects++;
               ST_ALR_DONE: repeat_marks++;
               ST_NONE:     empty_listings++;
               default: ;
            endcase
         end
      end
   endtask

   // ---------------------------------------------------------------------------
   // driver: new beat or idle decided on the falling edge, held until taken
   // ---------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || beat_taken) begin
         if (cmd_backlog.size() != 0 &&
             !(cmd_backlog[0].drain && awaited_results.size() != 0) &&
             $urandom_range(99) >= cmd_backlog[0].gap_pct) begin
            req_item <= cmd_backlog[0].beat;
            start    <= 1'b1;
            cmd_backlog.delete(0);
         end else begin
            start <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // monitor: results and accepted beats sampled on the rising edge
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      beat_taken <= !reset && start === 1'b1 && busy === 1'b0;
      if (!reset) begin
         // results of earlier beats come first, a beat taken now adds to the back
         if (rsp_strobe === 1'b1) check_result(rsp_item);
         if (start === 1'b1 && busy === 1'b0) begin
            beats_taken++;
            predict_results(req_item);
         end
      end
   end

   // ---------------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------------
   task automatic queue_cmd(logic [2:0] cmd, logic [19:0] key, logic [15:0] tag);
      queued_cmd_type qc;
      begin
         qc.beat.cmd          = cmd;
         qc.beat.priority_req = key;
         qc.beat.label        = tag;
         qc.drain             = drain_next;
         qc.gap_pct           = cur_gap;
         drain_next           = 1'b0;
         cmd_backlog.push_back(qc);
         if (cmd == CMD_INSERT && gen_fill < TABLE_DEPTH) begin
            gen_fill++;
            gen_keys.push_back(key);
         end else if (cmd == CMD_CLEAR) begin
            gen_fill = 0;
            gen_keys.delete();
         end
         if (cmd < CMD_SPARE_FIRST) random_beats++;
      end
   endtask

   // keys: a small pool for ties, the extremes, and the full range
   function automatic logic [19:0] pick_key();
      int roll;
      begin
         roll = $urandom_range(9);
         if (roll < 4) return 20'($urandom_range(15));
         if (roll == 4) return $urandom_range(1) ? '1 : '0;
         return 20'($urandom);
      end
   endfunction

   function automatic logic [15:0] pick_tag();
      int roll;
      begin
         roll = $urandom_range(19);
         if (roll == 0) return '0;
         if (roll == 1) return '1;
         return 16'($urandom);
      end
   endfunction

   // mostly a key already in the table, so marks and repeat marks are common
   function automatic logic [19:0] pick_mark_key();
      begin
         if (gen_keys.size() != 0 && $urandom_range(9) < 7)
            return gen_keys[$urandom_range(gen_keys.size() - 1)];
         return pick_key();
      end
   endfunction

   // ---------------------------------------------------------------------------
   // stimulus, reset and end of run
   // ---------------------------------------------------------------------------
   initial begin
      int fill_target;
      int roll;

      // directed: empty table, key extremes, ties, repeat marks, spare codes
      queue_cmd(CMD_LIST_DN, '0, '0);
      queue_cmd(CMD_LIST_PND, '1, '1);
      queue_cmd(CMD_COMPLETE, '0, '0);
      queue_cmd(CMD_INSERT, '0, '0);
      queue_cmd(CMD_INSERT, '1, '1);
      queue_cmd(CMD_INSERT, 20'd5, 16'h1111);
      queue_cmd(CMD_INSERT, 20'd5, 16'h2222);   // lands ahead of the first key 5
      queue_cmd(CMD_INSERT, 20'h80000, 16'haaaa);
      queue_cmd(CMD_INSERT, 20'd3, 16'h5555);
      queue_cmd(CMD_COMPLETE, 20'd5, '0);       // marks the newer key 5
      queue_cmd(CMD_COMPLETE, 20'd5, '0);       // first key 5 already done
      queue_cmd(CMD_COMPLETE, '1, 16'h0f0f);
      queue_cmd(CMD_COMPLETE, 20'd7, '0);       // no such key
      queue_cmd(CMD_SPARE_FIRST, 20'h55555, 16'h5555);
      queue_cmd(CMD_SPARE_MID, 20'haaaaa, 16'haaaa);
      queue_cmd(CMD_SPARE_LAST, '1, '1);
      queue_cmd(CMD_LIST_DN, '0, '0);
      queue_cmd(CMD_LIST_PND, '0, '0);
      queue_cmd(CMD_COMPLETE, '0, '0);
      queue_cmd(CMD_CLEAR, '1, '1);
      queue_cmd(CMD_LIST_PND, '0, '0);
      drain_next = 1'b1;                         // sender waits for a quiet table
      queue_cmd(CMD_INSERT, '1, '0);
      queue_cmd(CMD_LIST_PND, '0, '0);

      // fill to the brim with no idling: full rejects and a maximal listing
      random_beats = 0;
      cur_gap      = 0;
      queue_cmd(CMD_CLEAR, pick_key(), pick_tag());
      repeat (TABLE_DEPTH + 3) queue_cmd(CMD_INSERT, pick_key(), pick_tag());
      queue_cmd(CMD_LIST_PND, pick_key(), pick_tag());
      repeat (6) queue_cmd(CMD_COMPLETE, pick_mark_key(), pick_tag());
      queue_cmd(CMD_LIST_DN, pick_key(), pick_tag());
      queue_cmd(CMD_LIST_PND, pick_key(), pick_tag());
      queue_cmd(CMD_CLEAR, pick_key(), pick_tag());

      // random episodes: a fill, then marks, listings and the odd stray code
      cur_gap = IDLE_PCT;
      while (random_beats < RANDOM_BEATS) begin
         if ($urandom_range(7) == 0) fill_target = $urandom_range(20, TABLE_DEPTH + 2);
         else fill_target = $urandom_range(0, 10);
         repeat (fill_target) queue_cmd(CMD_INSERT, pick_key(), pick_tag());
         repeat ($urandom_range(4, 14)) begin
            roll = $urandom_range(99);
            if ($urandom_range(19) == 0) drain_next = 1'b1;
            if (roll < 40)      queue_cmd(CMD_COMPLETE, pick_mark_key(), pick_tag());
            else if (roll < 55) queue_cmd(CMD_LIST_DN, pick_key(), pick_tag());
            else if (roll < 70) queue_cmd(CMD_LIST_PND, pick_key(), pick_tag());
            else if (roll < 88) queue_cmd(CMD_INSERT, pick_key(), pick_tag());
            else if (roll < 94) queue_cmd(CMD_CLEAR, pick_key(), pick_tag());
            else queue_cmd(3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST)),
                           pick_key(), pick_tag());
         end
         if ($urandom_range(9) < 4) queue_cmd(CMD_CLEAR, pick_key(), pick_tag());
      end

      // synchronous reset, released on a falling edge
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // every beat handed over, then every result in, then a quiet tail
      while (cmd_backlog.size() != 0 || start) @(posedge clock);
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (2 * TABLE_DEPTH + 8) @(posedge clock);
      if (awaited_results.size() != 0) begin
         fail_count++;
         $display("%0t: %0d results never arrived", $time, awaited_results.size());
      end

      $display("run covered %0d command beats and %0d checked result beats",
               beats_taken, results_checked);
      $display("including %0d full rejects, %0d repeat marks and %0d empty listings",
               full_rejects, repeat_marks, empty_listings);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #4_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule

// ===== priority_sorted_task_table.f =====
rtl/core/pstt_pkg.sv
rtl/core/pstt_dp.sv
rtl/core/pstt_ctrl.sv
rtl/core/priority_sorted_task_table.sv
bench/priority_sorted_task_table_tb.sv
